FILE: rtl/core/qdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdc_pkg: shared types and constants of the quadrature dial counter
// Word layouts, the APB request bundle, the counter state and the Gray phase
// table used by the decoder.
// ----------------------------------------------------------------------------
package qdc_pkg;

  localparam int unsigned LimitW = 14;
  localparam int unsigned CountW = 17;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam logic signed [LimitW-1:0] LowerLimitReset = 14'sd0;
  localparam logic signed [LimitW-1:0] UpperLimitReset = 14'sd100;

  // Register index, taken from paddr[2]
  localparam logic RegLowerLimit = 1'b0;
  localparam logic RegUpperLimit = 1'b1;

  // Input op codes
  localparam logic OpSample = 1'b0;
  localparam logic OpInit   = 1'b1;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_BACK = 2'd1,
    STEP_FWD  = 2'd2
  } step_kind_e;

  typedef struct packed {
    logic op;
    logic clk_level;
    logic dt_level;
  } in_word_t;

  typedef struct packed {
    logic signed [LimitW-1:0] dial_value;
    logic                     dial_changed;
    step_kind_e               step_kind;
  } out_word_t;

  typedef struct packed {
    logic [1:0]               phase;
    logic signed [CountW-1:0] count;
    logic signed [LimitW-1:0] held;
  } dial_state_t;

  typedef struct packed {
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [DataW-1:0] pwdata;
  } apb_req_t;

  // Gray sequence {clk, dt}: 11, 01, 00, 10
  function automatic logic [1:0] phase_levels(input logic [1:0] phase);
    logic [1:0] lv;
    unique case (phase)
      2'd0:    lv = 2'b11;
      2'd1:    lv = 2'b01;
      2'd2:    lv = 2'b00;
      default: lv = 2'b10;
    endcase
    return lv;
  endfunction

  function automatic logic [1:0] phase_of(input logic [1:0] levels);
    logic [1:0] ph;
    unique case (levels)
      2'b11:   ph = 2'd0;
      2'b01:   ph = 2'd1;
      2'b00:   ph = 2'd2;
      default: ph = 2'd3;
    endcase
    return ph;
  endfunction

endpackage

FILE: rtl/core/qdc_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdc_regs: configuration registers
// APB register file holding the signed lower and upper dial limits.
// ----------------------------------------------------------------------------
module qdc_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  qdc_pkg::apb_req_t                apb_req_i,
  output logic [qdc_pkg::DataW-1:0]        prdata_o,
  output logic signed [qdc_pkg::LimitW-1:0] lower_limit_o,
  output logic signed [qdc_pkg::LimitW-1:0] upper_limit_o
);
  import qdc_pkg::*;

  logic signed [LimitW-1:0] lower_q;
  logic signed [LimitW-1:0] upper_q;
  logic                     wr_en;
  logic                     reg_sel;

  assign reg_sel = apb_req_i.paddr[2];
  assign wr_en   = apb_req_i.psel && apb_req_i.penable && apb_req_i.pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= LowerLimitReset;
      upper_q <= UpperLimitReset;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegLowerLimit: lower_q <= apb_req_i.pwdata[LimitW-1:0];
        default:       upper_q <= apb_req_i.pwdata[LimitW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegLowerLimit: prdata_o = {{(DataW-LimitW){lower_q[LimitW-1]}}, lower_q};
      default:       prdata_o = {{(DataW-LimitW){upper_q[LimitW-1]}}, upper_q};
    endcase
  end

  assign lower_limit_o = lower_q;
  assign upper_limit_o = upper_q;

endmodule

FILE: rtl/core/qdc_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdc_update: phase decode and count update
// Matches the sampled levels against the neighbor phases, steps and clamps
// the edge count (zeroed on init), and derives the dial value and change flag.
// ----------------------------------------------------------------------------
module qdc_update (
  input  qdc_pkg::in_word_t                 in_word_i,
  input  qdc_pkg::dial_state_t              state_i,
  input  logic signed [qdc_pkg::LimitW-1:0] lower_limit_i,
  input  logic signed [qdc_pkg::LimitW-1:0] upper_limit_i,
  output qdc_pkg::dial_state_t              state_o,
  output qdc_pkg::out_word_t                out_word_o
);
  import qdc_pkg::*;

  localparam int unsigned QuoW = CountW - 2;
  localparam logic signed [CountW:0] CntOne = 'sd1;

  logic [1:0]               levels;
  logic [1:0]               prev_ph;
  logic [1:0]               next_ph;
  logic signed [CountW:0]   cnt_ext;
  logic signed [CountW:0]   cnt_up;
  logic signed [CountW:0]   cnt_dn;
  logic signed [CountW:0]   floor4;
  logic signed [CountW:0]   cap4;
  logic signed [CountW-1:0] cnt_d;
  logic [1:0]               phase_d;
  step_kind_e               kind;
  logic signed [QuoW-1:0]   quo;
  logic signed [QuoW-1:0]   upper_ext;
  logic signed [LimitW-1:0] value;

  assign levels  = {in_word_i.clk_level, in_word_i.dt_level};
  assign prev_ph = state_i.phase - 2'd1;
  assign next_ph = state_i.phase + 2'd1;

  assign cnt_ext = {state_i.count[CountW-1], state_i.count};
  assign cnt_up  = cnt_ext + CntOne;
  assign cnt_dn  = cnt_ext - CntOne;
  assign floor4  = {{(CountW-1-LimitW){lower_limit_i[LimitW-1]}}, lower_limit_i, 2'b00};
  assign cap4    = {{(CountW-1-LimitW){upper_limit_i[LimitW-1]}}, upper_limit_i, 2'b00};

  always_comb begin
    phase_d = state_i.phase;
    cnt_d   = state_i.count;
    kind    = STEP_NONE;
    if (in_word_i.op == OpInit) begin
      phase_d = phase_of(levels);
      cnt_d   = '0;
    end else if (levels == phase_levels(prev_ph)) begin
      phase_d = prev_ph;
      cnt_d   = (cnt_dn < floor4) ? floor4[CountW-1:0] : cnt_dn[CountW-1:0];
      kind    = STEP_BACK;
    end else if (levels == phase_levels(next_ph)) begin
      phase_d = next_ph;
      cnt_d   = (cnt_up > cap4) ? cap4[CountW-1:0] : cnt_up[CountW-1:0];
      kind    = STEP_FWD;
    end
  end

  // Divide by four toward zero: shift, then round negative remainders up
  assign upper_ext = {{(QuoW-LimitW){upper_limit_i[LimitW-1]}}, upper_limit_i};

  always_comb begin
    quo = cnt_d[CountW-1:2];
    if (cnt_d[CountW-1] && (cnt_d[1:0] != 2'b00)) begin
      quo = quo + QuoW'(1);
    end
    value = (quo > upper_ext) ? upper_limit_i : quo[LimitW-1:0];
  end

  always_comb begin
    state_o.phase           = phase_d;
    state_o.count           = cnt_d;
    state_o.held            = value;
    out_word_o.dial_value   = value;
    out_word_o.dial_changed = (value != state_i.held);
    out_word_o.step_kind    = kind;
  end

endmodule

FILE: rtl/core/quadrature_dial_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_dial_counter: x4 quadrature decoder for a rotary dial
// Input register, single-pass phase/count update, result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_word_i) carries one word per
//   sample: op, clk_level, dt_level. Each accepted word yields exactly one
//   result word on the output channel (out_valid_o/out_ready_i/out_word_o):
//   dial_value, dial_changed and step_kind.
//   The accepted word is registered in the input register, then decoded
//   and written to the result register. One word per cycle is sustained
//   while the receiver keeps taking results; the per-item work is a phase
//   compare, a clamped increment or decrement of the 17-bit count and a shift.
//   When the receiver stalls, the result register holds its word and the
//   input register still takes one more word; in_ready_o drops only when
//   both are full, and no word is lost or repeated. Reset clears the phase
//   to 11, the edge count and held value to zero, the lower limit to 0 and
//   the upper limit to 100. The user must write the APB port (lower limit at
//   0x0, upper limit at 0x4) only while the block is idle; it does not enforce it.
// ----------------------------------------------------------------------------
module quadrature_dial_counter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  qdc_pkg::in_word_t         in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output qdc_pkg::out_word_t        out_word_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [qdc_pkg::AddrW-1:0] paddr,
  input  logic [qdc_pkg::DataW-1:0] pwdata,
  output logic [qdc_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import qdc_pkg::*;

  apb_req_t                 apb_req;
  logic signed [LimitW-1:0] lower_limit;
  logic signed [LimitW-1:0] upper_limit;

  logic        in_valid_q;
  in_word_t    in_q;
  logic        out_valid_q;
  out_word_t   out_q;
  out_word_t   out_d;
  dial_state_t state_q;
  dial_state_t state_d;
  logic        advance;
  logic        fire;

  assign apb_req = '{psel: psel, penable: penable, pwrite: pwrite,
                     paddr: paddr, pwdata: pwdata};
  assign pready  = 1'b1;

  qdc_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .apb_req_i     (apb_req),
    .prdata_o      (prdata),
    .lower_limit_o (lower_limit),
    .upper_limit_o (upper_limit)
  );

  qdc_update u_update (
    .in_word_i     (in_q),
    .state_i       (state_q),
    .lower_limit_i (lower_limit),
    .upper_limit_i (upper_limit),
    .state_o       (state_d),
    .out_word_o    (out_d)
  );

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{phase: 2'd0, count: '0, held: '0};
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      // advance the counter state only when the word moves on
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_word_i;
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_held_tracks_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q && (state_q.held == out_q.dial_value))
    else $error("held value does not match reported dial value");

  a_value_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (out_q.dial_value <= $past(upper_limit)))
    else $error("dial value above upper limit");

  a_change_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (out_q.dial_changed == (out_q.dial_value != $past(state_q.held))))
    else $error("dial_changed disagrees with previous held value");

  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q && $stable(in_q))
    else $error("pending input word dropped while result stalled");

endmodule

FILE: tb/quadrature_dial_counter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_dial_counter_tb: self-checking bench for the x4 dial decoder
// Drives clk/dt level words through the valid/ready input channel, predicts
// every result word from a local copy of the phase, edge count and limits,
// and compares each word taken from the output channel in order. Limits are
// set through the APB port between phases, corners first, then random turns.
// ----------------------------------------------------------------------------
module quadrature_dial_counter_tb;
  import qdc_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 6;
  localparam int IdlePct     = 23;
  // {clk, dt} levels of phases 0..3
  localparam logic [1:0] Gray [4] = '{2'b11, 2'b01, 2'b00, 2'b10};

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  in_word_t         in_word_i;
  logic             out_valid_o;
  logic             out_ready_i;
  out_word_t        out_word_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  // dial model state and limit copies
  logic [1:0] dial_phase = 2'd0;
  int         edge_cnt   = 0;
  int         held_val   = 0;
  int         lower_lim  = 0;
  int         upper_lim  = 100;

  out_word_t  dial_expect_q[$];
  int         mismatches = 0;
  int         cycles     = 0;
  bit         idle_en    = 1'b1;
  logic [1:0] turn_phase = 2'd0;

  quadrature_dial_counter uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic void note_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch in %s: expected %0d, got %0d", what, want, got);
    end
  endfunction

  function automatic out_word_t dial_predict(in_word_t w);
    logic [1:0] lv;
    logic [1:0] prv;
    logic [1:0] nxt;
    int         v;
    out_word_t  r;
    lv  = {w.clk_level, w.dt_level};
    prv = dial_phase - 2'd1;
    nxt = dial_phase + 2'd1;
    r.step_kind = STEP_NONE;
    if (w.op == OpInit) begin
      for (int i = 0; i < 4; i++) begin
        if (Gray[i] == lv) dial_phase = 2'(i);
      end
      edge_cnt = 0;
    end else if (lv == Gray[prv]) begin
      edge_cnt   = (edge_cnt - 1 < lower_lim * 4) ? lower_lim * 4 : edge_cnt - 1;
      dial_phase = prv;
      r.step_kind = STEP_BACK;
    end else if (lv == Gray[nxt]) begin
      edge_cnt   = (edge_cnt + 1 > upper_lim * 4) ? upper_lim * 4 : edge_cnt + 1;
      dial_phase = nxt;
      r.step_kind = STEP_FWD;
    end
    // int division truncates toward zero
    v = edge_cnt / 4;
    if (v > upper_lim) v = upper_lim;
    r.dial_value   = v[LimitW-1:0];
    r.dial_changed = (v != held_val);
    held_val = v;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      dial_expect_q.push_back(dial_predict(in_word_i));
    end
  end

  always @(posedge clk_i) begin : check_results
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (dial_expect_q.size() == 0) begin
        note_mismatch("unexpected word, dial_value", 0, int'(out_word_o.dial_value));
      end else begin
        want = dial_expect_q.pop_front();
        if (out_word_o.dial_value !== want.dial_value)
          note_mismatch("dial_value", int'(want.dial_value), int'(out_word_o.dial_value));
        if (out_word_o.dial_changed !== want.dial_changed)
          note_mismatch("dial_changed", int'(want.dial_changed),
                        int'(out_word_o.dial_changed));
        if (out_word_o.step_kind !== want.step_kind)
          note_mismatch("step_kind", int'(want.step_kind), int'(out_word_o.step_kind));
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= !(idle_en && $urandom_range(99) < IdlePct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_word(logic op, logic [1:0] lv);
    in_word_t w;
    w.op        = op;
    w.clk_level = lv[1];
    w.dt_level  = lv[0];
    while (idle_en && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and let every expected word come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (dial_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, int val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // read back the same register
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[LimitW-1:0] !== val[LimitW-1:0])
      note_mismatch("register readback", val, int'($signed(prdata[LimitW-1:0])));
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == RegLowerLimit) lower_lim = val;
    else upper_lim = val;
  endtask

  task automatic set_limits(int lo, int hi);
    wait_idle();
    write_reg(RegLowerLimit, lo);
    write_reg(RegUpperLimit, hi);
  endtask

  task automatic test_reset_walk();
    send_word(OpSample, 2'b11);  // same phase, no step
    send_word(OpSample, 2'b01);
    send_word(OpSample, 2'b00);
    send_word(OpSample, 2'b10);
    send_word(OpSample, 2'b11);  // back at phase 11, dial reaches 1
    send_word(OpSample, 2'b10);  // back, dial drops to 0
    send_word(OpSample, 2'b01);  // opposite phase, ignored
    send_word(OpSample, 2'b00);
    send_word(OpInit,   2'b00);
    send_word(OpSample, 2'b01);  // back below lower limit, hold at floor
    send_word(OpInit,   2'b01);
    send_word(OpInit,   2'b10);
    send_word(OpInit,   2'b11);
  endtask

  task automatic test_limit_corners();
    set_limits(8191, 8191);
    send_word(OpSample, 2'b10);  // floor jumps the count to the top
    set_limits(8191, -8192);     // lower above upper
    send_word(OpSample, 2'b11);
    send_word(OpSample, 2'b10);
    set_limits(-8192, -8192);
    send_word(OpInit, 2'b11);
    set_limits(-8192, 8191);
    send_word(OpSample, 2'b10);
    send_word(OpSample, 2'b00);
    set_limits(0, 100);
    send_word(OpInit, 2'b11);
    for (int i = 0; i < 8; i++) send_word(OpSample, Gray[(i + 1) % 4]);
    // cap the dial at once while the count stays above it
    set_limits(0, 1);
    send_word(OpSample, 2'b11);
    send_word(OpSample, 2'b10);
  endtask

  task automatic test_random_turns(int lo, int hi, int n_words, bit idle);
    int sent;
    int run;
    int pick;
    bit fwd;
    set_limits(lo, hi);
    idle_en    = idle;
    turn_phase = 2'($urandom_range(3));
    send_word(OpInit, Gray[turn_phase]);
    sent = 1;
    while (sent < n_words) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        run = $urandom_range(12, 1);
        fwd = 1'($urandom_range(1));
        repeat (run) begin
          turn_phase = fwd ? turn_phase + 2'd1 : turn_phase - 2'd1;
          send_word(OpSample, Gray[turn_phase]);
          sent++;
        end
      end else if (pick < 92) begin
        // same or opposite phase: no step
        send_word(OpSample, Gray[turn_phase + 2'(2 * $urandom_range(1))]);
        sent++;
      end else begin
        turn_phase = 2'($urandom_range(3));
        send_word(OpInit, Gray[turn_phase]);
        sent++;
      end
    end
    idle_en = 1'b1;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_walk();
    test_limit_corners();
    test_random_turns(-3, 3, 100, 1'b1);
    test_random_turns(-8192, 8191, 100, 1'b0);
    test_random_turns(2, -2, 100, 1'b1);
    test_random_turns(int'($urandom_range(16383)) - 8192,
                      int'($urandom_range(16383)) - 8192, 100, 1'b1);
    test_random_turns(-1, 1, 100, 1'b1);
    wait_idle();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: quadrature_dial_counter.f
rtl/core/qdc_pkg.sv
rtl/core/qdc_regs.sv
rtl/core/qdc_update.sv
rtl/core/quadrature_dial_counter.sv
tb/quadrature_dial_counter_tb.sv
